// ===== rtl/core/fedsb_pkg.sv =====
// Package for the farthest-evict depth sort buffer: types, widths and cell opcodes.
`default_nettype none
package fedsb_pkg;

  localparam int DEPTH_W       = 24;
  localparam int PAYLOAD_W     = 16;
  localparam int SLOTS_DEFAULT = 32;

  // Input command modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  // One input beat
  typedef struct packed {
    logic                 mode;
    logic [DEPTH_W-1:0]   depth;
    logic [PAYLOAD_W-1:0] payload;
  } item_t;

  // One result beat
  typedef struct packed {
    logic                 has_item;
    logic [DEPTH_W-1:0]   out_depth;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 last;
  } result_t;

  // Stored entry of one cell
  typedef struct packed {
    logic [DEPTH_W-1:0]   depth;
    logic [PAYLOAD_W-1:0] handle;
  } slot_t;

  // Operation broadcast to the whole row of cells
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,  // sorted insert, entries behind the new one move right
    OP_REPLACE = 2'd2,  // drop head, sorted insert of the new entry
    OP_POP     = 2'd3   // drop head, everything moves left
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [DEPTH_W-1:0]   depth;
    logic [PAYLOAD_W-1:0] handle;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/farthest_evict_depth_sort_buffer_top.sv =====
// Top level of the farthest-evict depth sort buffer: chain of sorted cells and output stage.
//
// Usage: items arrive on the item channel (item_valid/item_ready, payload item),
// results leave on the result channel (result_valid/result_ready, payload result).
// Entries are kept sorted in a row of SLOTS cells, farthest at cell 0, ties by
// slot index, so the farthest entry is always at the head.
// Insert with a free slot: no result beat.
// Insert into a full buffer: one result beat, registered in the cycle after accept.
// Flush: one beat per stored entry, one per cycle while the receiver takes them,
// first beat via the flush state and then the result register; an empty flush gives
// one marker beat, registered next cycle. No new item is taken until a flush has drained.
// Throughput: one insert per cycle while the result register is free; each
// operation is a single broadcast compare and neighbor shift across the row.
// A stalled receiver holds the result register and item_ready drops until it
// is taken. Reset empties the buffer and clears the result valid flag.
`default_nettype none
module farthest_evict_depth_sort_buffer_top import fedsb_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  result_t       result_next;
  logic          result_valid_next;

  logic          out_free;
  logic          acc;
  logic          full;
  logic          evict;
  cell_cmd_t     cmd;
  logic [IW-1:0] new_idx;

  logic          c_used [SLOTS];
  slot_t         c_slot [SLOTS];
  logic [IW-1:0] c_idx  [SLOTS];
  logic          c_g    [SLOTS];

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == ST_IDLE) && out_free;
  assign acc        = item_valid && item_ready;
  assign full       = (count == CW'(SLOTS));
  assign evict      = c_used[0] && (c_slot[0].depth > item.depth);

  // Command broadcast to the cell row
  always_comb begin
    cmd.op     = OP_HOLD;
    cmd.depth  = item.depth;
    cmd.handle = item.payload;
    new_idx    = count[IW-1:0];
    if (acc && (item.mode == MODE_INSERT)) begin
      if (!full) begin
        cmd.op = OP_INSERT;
      end else if (evict) begin
        cmd.op  = OP_REPLACE;
        new_idx = c_idx[0];
      end
    end else if ((state == ST_FLUSH) && out_free) begin
      cmd.op = OP_POP;
    end
  end

  // Row of cells, cell 0 holds the farthest entry
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic          l_used, r_used, l_g, r_g;
    slot_t         l_slot, r_slot;
    logic [IW-1:0] l_idx, r_idx;

    if (i == 0) begin : g_first
      assign l_used = 1'b0;
      assign l_slot = c_slot[i];
      assign l_idx  = c_idx[i];
      assign l_g    = 1'b1;
    end else begin : g_mid_l
      assign l_used = c_used[i-1];
      assign l_slot = c_slot[i-1];
      assign l_idx  = c_idx[i-1];
      assign l_g    = c_g[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign r_used = 1'b0;
      assign r_slot = c_slot[i];
      assign r_idx  = c_idx[i];
      assign r_g    = 1'b0;
    end else begin : g_mid_r
      assign r_used = c_used[i+1];
      assign r_slot = c_slot[i+1];
      assign r_idx  = c_idx[i+1];
      assign r_g    = c_g[i+1];
    end

    fedsb_cell #(.IW(IW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_idx    (new_idx),
      .left_used  (l_used),
      .left_slot  (l_slot),
      .left_idx   (l_idx),
      .left_g     (l_g),
      .right_used (r_used),
      .right_slot (r_slot),
      .right_idx  (r_idx),
      .right_g    (r_g),
      .used       (c_used[i]),
      .slot       (c_slot[i]),
      .idx        (c_idx[i]),
      .g          (c_g[i])
    );
  end

  // Control: fill count, flush drain and result register
  always_comb begin
    state_next        = state;
    count_next        = count;
    result_next       = result;
    result_valid_next = result_valid && !result_ready;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (item.mode == MODE_INSERT) begin
            if (!full) begin
              count_next = count + CW'(1);
            end else begin
              result_valid_next    = 1'b1;
              result_next.has_item = 1'b1;
              result_next.last     = 1'b1;
              if (evict) begin
                result_next.out_depth   = c_slot[0].depth;
                result_next.out_payload = c_slot[0].handle;
              end else begin
                result_next.out_depth   = item.depth;
                result_next.out_payload = item.payload;
              end
            end
          end else if (count == '0) begin
            // empty flush marker
            result_valid_next       = 1'b1;
            result_next.has_item    = 1'b0;
            result_next.out_depth   = '0;
            result_next.out_payload = '0;
            result_next.last        = 1'b1;
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          result_valid_next       = 1'b1;
          result_next.has_item    = 1'b1;
          result_next.out_depth   = c_slot[0].depth;
          result_next.out_payload = c_slot[0].handle;
          result_next.last        = (count == CW'(1));
          count_next              = count - CW'(1);
          if (count == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/fedsb_cell.sv =====
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`default_nettype none
module fedsb_cell import fedsb_pkg::*; #(
  parameter int IW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] new_idx,
  input  logic          left_used,
  input  slot_t         left_slot,
  input  logic [IW-1:0] left_idx,
  input  logic          left_g,
  input  logic          right_used,
  input  slot_t         right_slot,
  input  logic [IW-1:0] right_idx,
  input  logic          right_g,
  output logic          used,
  output slot_t         slot,
  output logic [IW-1:0] idx,
  output logic          g
);

  logic          used_next;
  slot_t         slot_next;
  logic [IW-1:0] idx_next;
  slot_t         new_slot;

  assign new_slot = '{depth: cmd.depth, handle: cmd.handle};

  // This entry sorts ahead of the new one: farther, or equal and lower slot index
  assign g = used && ((slot.depth > cmd.depth) ||
                      ((slot.depth == cmd.depth) && (idx < new_idx)));

  // Next-state selection per operation
  always_comb begin
    used_next = used;
    slot_next = slot;
    idx_next  = idx;
    case (cmd.op)
      OP_INSERT: begin
        if (!g) begin
          if (left_g) begin
            used_next = 1'b1;
            slot_next = new_slot;
            idx_next  = new_idx;
          end else begin
            used_next = left_used;
            slot_next = left_slot;
            idx_next  = left_idx;
          end
        end
      end
      OP_REPLACE: begin
        if (right_g) begin
          used_next = right_used;
          slot_next = right_slot;
          idx_next  = right_idx;
        end else if (g) begin
          used_next = 1'b1;
          slot_next = new_slot;
          idx_next  = new_idx;
        end
      end
      OP_POP: begin
        used_next = right_used;
        slot_next = right_slot;
        idx_next  = right_idx;
      end
      default: begin
        used_next = used;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      used <= used_next;
    end
  end

  // Entry data, only meaningful while used
  always_ff @(posedge clk) begin
    slot <= slot_next;
    idx  <= idx_next;
  end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the farthest-evict depth sort buffer.
`default_nettype none
module tb_top;
  import fedsb_pkg::*;

  localparam int SLOTS          = SLOTS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int END_SETTLE     = 20;
  localparam int PHASE_ITEMS    = 40;

  // Predicts the draw stream: slot buffer copy plus queue of expected beats
  class draw_order_scoreboard;
    bit                   occupied      [SLOTS];
    logic [DEPTH_W-1:0]   stored_depth  [SLOTS];
    logic [PAYLOAD_W-1:0] stored_handle [SLOTS];
    result_t              draw_queue[$];
    int                   errors;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return draw_queue.size();
    endfunction

    // farthest occupied slot, lower index wins ties, -1 when empty
    function int farthest_slot();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (occupied[i] && (best < 0 || stored_depth[i] > stored_depth[best])) best = i;
      end
      return best;
    endfunction

    function void add_draw(logic has, logic [DEPTH_W-1:0] d, logic [PAYLOAD_W-1:0] h,
                           logic fin);
      result_t r;
      r.has_item    = has;
      r.out_depth   = d;
      r.out_payload = h;
      r.last        = fin;
      draw_queue.push_back(r);
    endfunction

    // accepted input beat: update slots, queue the draws it causes
    function void take_item(item_t it);
      int idx;
      int nxt;
      int free_idx;
      int count;
      if (it.mode == MODE_INSERT) begin
        free_idx = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!occupied[i]) free_idx = i;
        end
        if (free_idx >= 0) begin
          occupied[free_idx]      = 1'b1;
          stored_depth[free_idx]  = it.depth;
          stored_handle[free_idx] = it.payload;
          return;
        end
        idx = farthest_slot();
        if (stored_depth[idx] > it.depth) begin
          add_draw(1'b1, stored_depth[idx], stored_handle[idx], 1'b1);
          stored_depth[idx]  = it.depth;
          stored_handle[idx] = it.payload;
        end else begin
          add_draw(1'b1, it.depth, it.payload, 1'b1);
        end
      end else begin
        count = 0;
        idx   = farthest_slot();
        while (idx >= 0) begin
          occupied[idx] = 1'b0;
          nxt = farthest_slot();
          add_draw(1'b1, stored_depth[idx], stored_handle[idx], nxt < 0);
          count++;
          idx = nxt;
        end
        if (count == 0) add_draw(1'b0, '0, '0, 1'b1);
      end
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, got);
        errors++;
      end
    endfunction

    // accepted result beat against the oldest expectation
    function void check_draw(result_t got);
      result_t exp;
      if (draw_queue.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got 0x%0h", $time, got);
        errors++;
        return;
      end
      exp = draw_queue.pop_front();
      compare_field("has_item", exp.has_item, got.has_item);
      compare_field("out_depth", exp.out_depth, got.out_depth);
      compare_field("out_payload", exp.out_payload, got.out_payload);
      compare_field("last", exp.last, got.last);
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int src_idle_pct  = 12;
  int sink_idle_pct = 60;
  int sent_items    = 0;
  int quiet_cycles  = 0;

  draw_order_scoreboard sb = new();

  farthest_evict_depth_sort_buffer_top #(.SLOTS(SLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_draw(result);
  end

  // watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic item_t make_item(logic m, logic [DEPTH_W-1:0] d,
                                      logic [PAYLOAD_W-1:0] p);
    item_t it;
    it.mode    = m;
    it.depth   = d;
    it.payload = p;
    return it;
  endfunction

  // depths biased toward ties and the range ends
  function automatic logic [DEPTH_W-1:0] rand_depth();
    case ($urandom_range(4))
      0:       return DEPTH_W'($urandom_range(7));
      1:       return {DEPTH_W{1'b1}} - DEPTH_W'($urandom_range(3));
      default: return DEPTH_W'($urandom);
    endcase
  endfunction

  // one beat on the item channel, with an optional idle gap first
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    sb.take_item(it);
    sent_items++;
  endtask

  task automatic send_insert(input logic [DEPTH_W-1:0] d, input logic [PAYLOAD_W-1:0] p);
    send_item(make_item(MODE_INSERT, d, p));
  endtask

  // flush with junk in the ignored fields
  task automatic send_flush();
    send_item(make_item(MODE_FLUSH, DEPTH_W'($urandom), PAYLOAD_W'($urandom)));
  endtask

  // hold the sender until every expected draw has come out
  task automatic drain_draws();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // one random sequence: noise, a partial fill, or a fill past full
  task automatic random_sequence();
    int roll;
    int n;
    roll = $urandom_range(99);
    if (roll < 10) begin
      if ($urandom_range(1)) send_flush();
      else send_insert(rand_depth(), PAYLOAD_W'($urandom));
    end else if (roll < 55) begin
      n = $urandom_range(1, 12);
      repeat (n) send_insert(rand_depth(), PAYLOAD_W'($urandom));
      if ($urandom_range(3) != 0) send_flush();
    end else begin
      n = SLOTS + $urandom_range(1, 10);
      repeat (n) send_insert(rand_depth(), PAYLOAD_W'($urandom));
      send_flush();
    end
  endtask

  task automatic random_phase(input int src_pct, input int sink_pct);
    int stop_at;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at = sent_items + PHASE_ITEMS;
    while (sent_items < stop_at) random_sequence();
    drain_draws();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty flush, extremes, ties on flush order
    send_item(make_item(MODE_FLUSH, {DEPTH_W{1'b1}}, {PAYLOAD_W{1'b1}}));
    send_insert('0, '0);
    send_insert({DEPTH_W{1'b1}}, {PAYLOAD_W{1'b1}});
    send_insert(24'h000100, 16'h1234);
    send_insert({DEPTH_W{1'b1}}, 16'h0001);
    send_flush();
    send_flush();

    // directed: full buffer, farthest entries tied at the top
    for (int i = 0; i < SLOTS; i++) begin
      send_insert((i < 2) ? 24'h800000 : DEPTH_W'(i * 24'h1000), PAYLOAD_W'(16'hA000 + i));
    end
    send_insert({DEPTH_W{1'b1}}, 16'h5555);  // farther than all: emitted at once
    send_insert(24'h800000, 16'h6666);       // equal to farthest: emitted at once
    send_insert(24'h000010, 16'h7777);       // nearer: evicts the farthest
    send_insert('0, 16'h8888);               // evicts the other tied entry
    send_flush();
    drain_draws();

    // random traffic in three idling phases
    random_phase(12, 60);
    random_phase(60, 12);
    random_phase(0, 0);

    repeat (END_SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
